/* rtl/mlr_pkg.sv */
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared widths, types and codes for the midpoint line rasterizer.
// ----------------------------------------------------------------------------
package mlr_pkg;

  // Coordinate width of endpoints and pixels
  localparam int COORD_BITS = 12;
  // Decision value and increments: 2*(minor - major) needs COORD_BITS+2 bits
  localparam int DEC_BITS   = COORD_BITS + 4;
  localparam int COLOR_BITS = 24;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DEC_BITS-1:0]   dec_t;
  typedef logic [COLOR_BITS-1:0]        color_t;

  // Request kinds
  typedef enum logic {
    MODE_START = 1'b0,
    MODE_STEP  = 1'b1
  } mode_t;

  // One request as held in the input register
  typedef struct packed {
    mode_t  mode;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
    color_t line_color;
  } item_t;

  // One emitted pixel
  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t color;
    logic   last;
  } pixel_t;

  // Sign-extend a coordinate to decision width
  function automatic dec_t widen(coord_t c);
    return {{(DEC_BITS-COORD_BITS){c[COORD_BITS-1]}}, c};
  endfunction

endpackage

/* rtl/mlr_input_stage.sv */
// ----------------------------------------------------------------------------
// mlr_input_stage
// Input register: captures one request and holds it until the engine takes it.
// ----------------------------------------------------------------------------
module mlr_input_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  mlr_pkg::item_t in_item,
  input  logic           advance,
  output logic           stage_valid,
  output mlr_pkg::item_t stage_item
);

  logic           valid_r;
  logic           valid_nxt;
  mlr_pkg::item_t item_r;
  logic           accept;

  // Stall only while a held request cannot move on this cycle
  assign in_stall    = valid_r && !advance;
  assign accept      = in_valid && !in_stall;
  assign stage_valid = valid_r;
  assign stage_item  = item_r;

  // Valid flag next value
  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

endmodule

/* rtl/mlr_engine.sv */
// ----------------------------------------------------------------------------
// mlr_engine
// Line state and the single-pass setup / step arithmetic of the rasterizer.
// ----------------------------------------------------------------------------
module mlr_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  mlr_pkg::item_t  item,
  output logic            res_valid,
  output mlr_pkg::pixel_t res_pixel
);

  // Line state
  mlr_pkg::coord_t cur_x_r,        cur_x_nxt;
  mlr_pkg::coord_t cur_y_r,        cur_y_nxt;
  mlr_pkg::coord_t major_end_r,    major_end_nxt;
  mlr_pkg::dec_t   decision_r,     decision_nxt;
  mlr_pkg::dec_t   inc_diagonal_r, inc_diagonal_nxt;
  mlr_pkg::dec_t   inc_straight_r, inc_straight_nxt;
  logic            x_is_major_r,   x_is_major_nxt;
  logic            minor_down_r,   minor_down_nxt;
  logic            line_active_r,  line_active_nxt;
  mlr_pkg::color_t held_color_r,   held_color_nxt;

  // Setup terms
  mlr_pkg::dec_t   dx, dy, adx, ady, a_maj, a_min;
  logic            s_x_major, s_swap;
  mlr_pkg::coord_t x1, y1, x2, y2;

  // Step terms
  logic            move;
  mlr_pkg::coord_t minor_cur, minor_new, major_new;
  logic            last;

  // Endpoint deltas, magnitudes and ordering along the major axis
  always_comb begin
    dx        = mlr_pkg::widen(item.x_end) - mlr_pkg::widen(item.x_start);
    dy        = mlr_pkg::widen(item.y_end) - mlr_pkg::widen(item.y_start);
    adx       = dx[mlr_pkg::DEC_BITS-1] ? -dx : dx;
    ady       = dy[mlr_pkg::DEC_BITS-1] ? -dy : dy;
    s_x_major = ($signed(ady) <= $signed(adx));
    a_maj     = s_x_major ? adx : ady;
    a_min     = s_x_major ? ady : adx;
    s_swap    = s_x_major ? ($signed(item.x_start) > $signed(item.x_end))
                          : ($signed(item.y_start) > $signed(item.y_end));
    x1        = s_swap ? item.x_end   : item.x_start;
    y1        = s_swap ? item.y_end   : item.y_start;
    x2        = s_swap ? item.x_start : item.x_end;
    y2        = s_swap ? item.y_start : item.y_end;
  end

  // One step along the major axis
  always_comb begin
    if (x_is_major_r) begin
      move      = !decision_r[mlr_pkg::DEC_BITS-1];
      minor_cur = cur_y_r;
      major_new = cur_x_r + mlr_pkg::coord_t'(1);
    end else begin
      move      = !decision_r[mlr_pkg::DEC_BITS-1] && (decision_r != '0);
      minor_cur = cur_x_r;
      major_new = cur_y_r + mlr_pkg::coord_t'(1);
    end
    if (!move) begin
      minor_new = minor_cur;
    end else if (minor_down_r) begin
      minor_new = minor_cur - mlr_pkg::coord_t'(1);
    end else begin
      minor_new = minor_cur + mlr_pkg::coord_t'(1);
    end
  end

  // Request decode: next state and result
  always_comb begin
    cur_x_nxt        = cur_x_r;
    cur_y_nxt        = cur_y_r;
    major_end_nxt    = major_end_r;
    decision_nxt     = decision_r;
    inc_diagonal_nxt = inc_diagonal_r;
    inc_straight_nxt = inc_straight_r;
    x_is_major_nxt   = x_is_major_r;
    minor_down_nxt   = minor_down_r;
    line_active_nxt  = line_active_r;
    held_color_nxt   = held_color_r;
    last             = 1'b0;
    res_valid        = 1'b0;
    unique case (item.mode)
      mlr_pkg::MODE_START: begin
        res_valid        = 1'b1;
        held_color_nxt   = item.line_color;
        x_is_major_nxt   = s_x_major;
        minor_down_nxt   = s_x_major ? ($signed(y2) < $signed(y1))
                                     : ($signed(x2) < $signed(x1));
        decision_nxt     = (a_min <<< 1) - a_maj;
        inc_diagonal_nxt = (a_min <<< 1) - (a_maj <<< 1);
        inc_straight_nxt = a_min <<< 1;
        major_end_nxt    = s_x_major ? x2 : y2;
        last             = s_x_major ? (x1 == x2) : (y1 == y2);
        cur_x_nxt        = x1;
        cur_y_nxt        = y1;
        line_active_nxt  = !last;
      end
      mlr_pkg::MODE_STEP: begin
        if (line_active_r) begin
          res_valid    = 1'b1;
          decision_nxt = decision_r + (move ? inc_diagonal_r : inc_straight_r);
          if (x_is_major_r) begin
            cur_x_nxt = major_new;
            cur_y_nxt = minor_new;
          end else begin
            cur_x_nxt = minor_new;
            cur_y_nxt = major_new;
          end
          last            = ($signed(major_new) >= $signed(major_end_r));
          line_active_nxt = !last;
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
    res_pixel.x     = cur_x_nxt;
    res_pixel.y     = cur_y_nxt;
    res_pixel.color = held_color_nxt;
    res_pixel.last  = last;
  end

  // State registers, updated when a request leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r        <= '0;
      cur_y_r        <= '0;
      major_end_r    <= '0;
      decision_r     <= '0;
      inc_diagonal_r <= '0;
      inc_straight_r <= '0;
      x_is_major_r   <= 1'b0;
      minor_down_r   <= 1'b0;
      line_active_r  <= 1'b0;
      held_color_r   <= '0;
    end else if (fire) begin
      cur_x_r        <= cur_x_nxt;
      cur_y_r        <= cur_y_nxt;
      major_end_r    <= major_end_nxt;
      decision_r     <= decision_nxt;
      inc_diagonal_r <= inc_diagonal_nxt;
      inc_straight_r <= inc_straight_nxt;
      x_is_major_r   <= x_is_major_nxt;
      minor_down_r   <= minor_down_nxt;
      line_active_r  <= line_active_nxt;
      held_color_r   <= held_color_nxt;
    end
  end

endmodule

/* rtl/mlr_output_stage.sv */
// ----------------------------------------------------------------------------
// mlr_output_stage
// Result register and the advance decision for the request in flight.
// ----------------------------------------------------------------------------
module mlr_output_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            stage_valid,
  input  logic            res_valid,
  input  mlr_pkg::pixel_t res_pixel,
  output logic            advance,
  output logic            out_valid,
  input  logic            out_stall,
  output mlr_pkg::pixel_t out_pixel
);

  logic            valid_r;
  logic            valid_nxt;
  mlr_pkg::pixel_t pixel_r;
  logic            free;
  logic            load;

  // Register can take a pixel when empty or being drained this cycle
  assign free      = !valid_r || !out_stall;
  assign advance   = stage_valid && (free || !res_valid);
  assign load      = advance && res_valid;
  assign out_valid = valid_r;
  assign out_pixel = pixel_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      pixel_r <= res_pixel;
    end
  end

endmodule

/* rtl/midpoint_line_rasterizer_core.sv */
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_core
// Midpoint line rasterizer: start requests set up a line and emit its first
// pixel, step requests emit one pixel each along the major axis.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall  mode, endpoints, line color
//  out_     output     out_valid/out_stall pixel x/y, color, last mark
//
//  One request per clock while in_stall is low; a pixel leaves through the
//  input register, then the result register. Setup and step each fit in
//  one add-and-compare pass between the two registers.
//  Synchronous active-low reset clears the line state: no line active.
//  A stalled result holds the result register; the input register keeps
//  taking requests until a second pixel would have nowhere to go.
//  A step request with no active line leaves no pixel and never waits.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_mode,
  input  mlr_pkg::coord_t        in_x_start,
  input  mlr_pkg::coord_t        in_y_start,
  input  mlr_pkg::coord_t        in_x_end,
  input  mlr_pkg::coord_t        in_y_end,
  input  mlr_pkg::color_t        in_line_color,
  output logic                   out_valid,
  input  logic                   out_stall,
  output mlr_pkg::coord_t        out_pixel_x,
  output mlr_pkg::coord_t        out_pixel_y,
  output mlr_pkg::color_t        out_pixel_color,
  output logic                   out_last_pixel
);

  mlr_pkg::item_t  in_item;
  mlr_pkg::item_t  stage_item;
  logic            stage_valid;
  logic            advance;
  logic            res_valid;
  mlr_pkg::pixel_t res_pixel;
  mlr_pkg::pixel_t out_pixel;

  // Pack the request fields
  always_comb begin
    in_item.mode       = mlr_pkg::mode_t'(in_mode);
    in_item.x_start    = in_x_start;
    in_item.y_start    = in_y_start;
    in_item.x_end      = in_x_end;
    in_item.y_end      = in_y_end;
    in_item.line_color = in_line_color;
  end

  mlr_input_stage u_input (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  mlr_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .item      (stage_item),
    .res_valid (res_valid),
    .res_pixel (res_pixel)
  );

  mlr_output_stage u_output (
    .clk         (clk),
    .rst_n       (rst_n),
    .stage_valid (stage_valid),
    .res_valid   (res_valid),
    .res_pixel   (res_pixel),
    .advance     (advance),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_pixel   (out_pixel)
  );

  // Unpack the pixel fields
  assign out_pixel_x     = out_pixel.x;
  assign out_pixel_y     = out_pixel.y;
  assign out_pixel_color = out_pixel.color;
  assign out_last_pixel  = out_pixel.last;

endmodule
